[hw/rtl/lfd_pkg.sv]
package lfd_pkg;

    localparam int LFD_BYTE_W  = 8;
    localparam int LFD_LIMIT_W = 9;
    localparam int LFD_CFG_IDX_W = 2;
    localparam int LFD_CFG_DATA_W = 9;

    // Longest strip the design supports; the frame length never exceeds it
    // nor the 256 positions the 8-bit pixel index can name.
    localparam int LFD_MAX_LEDS = 256;
    localparam logic [LFD_LIMIT_W-1:0] LFD_FRAME_CAP =
        LFD_LIMIT_W'((LFD_MAX_LEDS < 256) ? LFD_MAX_LEDS : 256);

    // Header bytes
    localparam logic [LFD_BYTE_W-1:0] MAGIC_UPPER_A = 8'h41; // 'A'
    localparam logic [LFD_BYTE_W-1:0] MAGIC_LOWER_D = 8'h64; // 'd'
    localparam logic [LFD_BYTE_W-1:0] MAGIC_LOWER_A = 8'h61; // 'a'
    localparam logic [LFD_BYTE_W-1:0] CHECK_XOR     = 8'h55;

    // Configuration register indexes
    localparam logic [LFD_CFG_IDX_W-1:0] CFG_COLOR_ORDER = 2'd0;
    localparam logic [LFD_CFG_IDX_W-1:0] CFG_LED_COUNT   = 2'd1;

    localparam logic [LFD_CFG_DATA_W-1:0] LED_COUNT_RESET = 9'd38;

    // Color order codes; anything else passes through
    localparam logic [2:0] CO_PASS    = 3'd0;
    localparam logic [2:0] CO_SWAP_GB = 3'd1;
    localparam logic [2:0] CO_SWAP_RG = 3'd2;
    localparam logic [2:0] CO_ROTATE  = 3'd3;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_D    = 3'd1,
        PH_A2   = 3'd2,
        PH_HI   = 3'd3,
        PH_LO   = 3'd4,
        PH_CHK  = 3'd5,
        PH_PIX  = 3'd6
    } t_phase;

    typedef struct packed {
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_pixel;

endpackage

[hw/rtl/lfd_byte_if.sv]
interface lfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

[hw/rtl/lfd_pix_if.sv]
interface lfd_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;

    modport source (output valid, output pixel_index, output red, output green,
                    output blue, output frame_end, input ready);
    modport sink   (input valid, input pixel_index, input red, input green,
                    input blue, input frame_end, output ready);
endinterface

[hw/rtl/lfd_cfg_if.sv]
interface lfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/lfd_parser.sv]
module lfd_parser
    import lfd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [LFD_BYTE_W-1:0]  i_byte,
    input  logic [2:0]             i_color_order,
    input  logic [LFD_LIMIT_W-1:0] i_frame_limit,
    output logic                   o_pix_valid,
    output t_pixel                 o_pix
);

    t_phase                r_phase, n_phase;
    logic [LFD_BYTE_W-1:0] r_count_high, n_count_high;
    logic [LFD_BYTE_W-1:0] r_count_low, n_count_low;
    logic [7:0]            r_pixel_counter, n_pixel_counter;
    logic [1:0]            r_byte_in_pixel, n_byte_in_pixel;
    logic [LFD_BYTE_W-1:0] r_held_first, n_held_first;
    logic [LFD_BYTE_W-1:0] r_held_second, n_held_second;

    logic [LFD_LIMIT_W-1:0] next_count;
    logic                   last_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HUNT;
            r_count_high    <= '0;
            r_count_low     <= '0;
            r_pixel_counter <= '0;
            r_byte_in_pixel <= '0;
            r_held_first    <= '0;
            r_held_second   <= '0;
        end else begin
            r_phase         <= n_phase;
            r_count_high    <= n_count_high;
            r_count_low     <= n_count_low;
            r_pixel_counter <= n_pixel_counter;
            r_byte_in_pixel <= n_byte_in_pixel;
            r_held_first    <= n_held_first;
            r_held_second   <= n_held_second;
        end
    end

    assign next_count = {1'b0, r_pixel_counter} + LFD_LIMIT_W'(1);
    assign last_pixel = (next_count >= i_frame_limit);

    // Color reorder of the current triple
    always_comb begin
        o_pix.pixel_index = r_pixel_counter;
        o_pix.frame_end   = last_pixel;
        case (i_color_order)
            CO_SWAP_GB: begin
                o_pix.red   = r_held_first;
                o_pix.green = i_byte;
                o_pix.blue  = r_held_second;
            end
            CO_SWAP_RG: begin
                o_pix.red   = r_held_second;
                o_pix.green = r_held_first;
                o_pix.blue  = i_byte;
            end
            CO_ROTATE: begin
                o_pix.red   = r_held_second;
                o_pix.green = i_byte;
                o_pix.blue  = r_held_first;
            end
            default: begin
                o_pix.red   = r_held_first;
                o_pix.green = r_held_second;
                o_pix.blue  = i_byte;
            end
        endcase
    end

    always_comb begin
        n_phase         = r_phase;
        n_count_high    = r_count_high;
        n_count_low     = r_count_low;
        n_pixel_counter = r_pixel_counter;
        n_byte_in_pixel = r_byte_in_pixel;
        n_held_first    = r_held_first;
        n_held_second   = r_held_second;
        o_pix_valid     = 1'b0;

        if (i_accept) begin
            case (r_phase)
                PH_HUNT: begin
                    n_phase = (i_byte == MAGIC_UPPER_A) ? PH_D : PH_HUNT;
                end
                PH_D: begin
                    if (i_byte == MAGIC_LOWER_D)      n_phase = PH_A2;
                    else if (i_byte == MAGIC_UPPER_A) n_phase = PH_D;
                    else                              n_phase = PH_HUNT;
                end
                PH_A2: begin
                    if (i_byte == MAGIC_LOWER_A)      n_phase = PH_HI;
                    else if (i_byte == MAGIC_UPPER_A) n_phase = PH_D;
                    else                              n_phase = PH_HUNT;
                end
                PH_HI: begin
                    n_count_high = i_byte;
                    n_phase      = PH_LO;
                end
                PH_LO: begin
                    n_count_low = i_byte;
                    n_phase     = PH_CHK;
                end
                PH_CHK: begin
                    if ((i_byte == (r_count_high ^ r_count_low ^ CHECK_XOR)) &&
                        (i_frame_limit != '0)) begin
                        n_phase         = PH_PIX;
                        n_pixel_counter = '0;
                        n_byte_in_pixel = '0;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_PIX: begin
                    case (r_byte_in_pixel)
                        2'd0: begin
                            n_held_first    = i_byte;
                            n_byte_in_pixel = 2'd1;
                        end
                        2'd1: begin
                            n_held_second   = i_byte;
                            n_byte_in_pixel = 2'd2;
                        end
                        default: begin
                            o_pix_valid     = 1'b1;
                            n_byte_in_pixel = 2'd0;
                            if (last_pixel) begin
                                n_phase         = PH_HUNT;
                                n_pixel_counter = '0;
                            end else begin
                                n_pixel_counter = next_count[7:0];
                            end
                        end
                    endcase
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_bip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_in_pixel != 2'd3)
        else $error("byte_in_pixel reached an unused code");

    a_last_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix_valid && o_pix.frame_end) |=> (r_phase == PH_HUNT))
        else $error("frame end did not return to hunting");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix_valid && !o_pix.frame_end) |=>
            (r_pixel_counter == $past(r_pixel_counter) + 8'd1))
        else $error("pixel index did not advance by one");
`endif

endmodule

[hw/rtl/led_frame_header_pixel_decoder.sv]
// LED frame decoder.
// i_byte  : serial bytes in, one request per byte. Framing is the magic word
//           'A','d','a', count high, count low, check (high ^ low ^ 0x55),
//           then R,G,B triples.
// o_pix   : one request per completed triple: pixel index, reordered color,
//           and frame_end on the last pixel of the frame.
// i_cfg   : register writes, index 0 color_order, index 1 led_count. Always
//           ready; write only while no pixel is pending.
// Frame length is min(led_count, 256); a count of zero drops the frame.
// Output: a pixel is shown on o_pix in the cycle after its third color byte
//          is accepted.
// Throughput: one byte per cycle unless o_pix stalls. The parser state is
//          updated as a byte is taken; pixels land in one output register.
// Stall: while o_pix holds an untaken pixel, i_byte stays ready only in the
//          cycle that pixel is taken; bytes that make no pixel wait as well.
// Reset (i_rst_n low, synchronous): parser hunts for 'A', output empty,
//          color_order = 0, led_count = 38.
module led_frame_header_pixel_decoder
    import lfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    lfd_byte_if.sink   i_byte,
    lfd_pix_if.source  o_pix,
    lfd_cfg_if.sink    i_cfg
);

    logic [2:0]                r_color_order;
    logic [LFD_CFG_DATA_W-1:0] r_led_count;
    logic [LFD_LIMIT_W-1:0]    frame_limit;

    logic   byte_accept;
    logic   pix_valid;
    t_pixel pix;

    logic   r_out_valid, n_out_valid;
    t_pixel r_out;

    // Config port: never back-pressures.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_order <= CO_PASS;
            r_led_count   <= LED_COUNT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_COLOR_ORDER: r_color_order <= i_cfg.data[2:0];
                CFG_LED_COUNT:   r_led_count   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Clamp the programmed count to what the strip index can address
    assign frame_limit = (r_led_count > LFD_FRAME_CAP) ? LFD_FRAME_CAP : r_led_count;

    // Take a byte whenever the output slot is free or drains this cycle
    assign i_byte.ready = !r_out_valid || o_pix.ready;
    assign byte_accept  = i_byte.valid && i_byte.ready;

    lfd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (byte_accept),
        .i_byte        (i_byte.data_byte),
        .i_color_order (r_color_order),
        .i_frame_limit (frame_limit),
        .o_pix_valid   (pix_valid),
        .o_pix         (pix)
    );

    // Output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (byte_accept && pix_valid) begin
            n_out_valid = 1'b1;
        end else if (o_pix.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (byte_accept && pix_valid) begin
            r_out <= pix;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.pixel_index = r_out.pixel_index;
    assign o_pix.red         = r_out.red;
    assign o_pix.green       = r_out.green;
    assign o_pix.blue        = r_out.blue;
    assign o_pix.frame_end   = r_out.frame_end;

`ifndef ASSERT_OFF
    a_pix_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (byte_accept && pix_valid) |=> r_out_valid)
        else $error("generated pixel was not registered");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_byte.ready)
        else $error("input stalled with an empty output slot");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_pix.ready) |-> !byte_accept)
        else $error("byte taken while a pixel is stalled");
`endif

endmodule

[test/lfd_pixel_checker.sv]
`timescale 1ns / 100ps

// Watches the byte, pixel and register channels, keeps its own copy of the
// decoder state and checks every pixel taken against the oldest prediction.
module lfd_pixel_checker
    import lfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lfd_byte_if  byte_ch,
    lfd_pix_if   pix_ch,
    lfd_cfg_if   cfg_ch,
    output int   o_pending,
    output int   o_mismatches
);

    logic [2:0]             color_order;
    logic [LFD_LIMIT_W-1:0] led_count;
    t_phase                 phase;
    logic [7:0]             count_hi;
    logic [7:0]             count_lo;
    logic [7:0]             pixel_num;
    logic [1:0]             byte_slot;
    logic [7:0]             first_color;
    logic [7:0]             second_color;
    t_pixel                 pixel_expect_q[$];
    int                     mismatches = 0;

    assign o_mismatches = mismatches;

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    function automatic int frame_len();
        return (led_count > LFD_FRAME_CAP) ? int'(LFD_FRAME_CAP) : int'(led_count);
    endfunction

    // a byte that breaks the magic word starts a new match if it is 'A'
    function automatic t_phase restart_from(input logic [7:0] b);
        return (b == MAGIC_UPPER_A) ? PH_D : PH_HUNT;
    endfunction

    // advances the parser by one byte; a finished triple queues a pixel
    function automatic void decode_byte(input logic [7:0] b);
        t_pixel     px;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] bl;
        case (phase)
            PH_HUNT: phase = restart_from(b);
            PH_D:    phase = (b == MAGIC_LOWER_D) ? PH_A2 : restart_from(b);
            PH_A2:   phase = (b == MAGIC_LOWER_A) ? PH_HI : restart_from(b);
            PH_HI: begin
                count_hi = b;
                phase    = PH_LO;
            end
            PH_LO: begin
                count_lo = b;
                phase    = PH_CHK;
            end
            PH_CHK: begin
                if (b == (count_hi ^ count_lo ^ CHECK_XOR) && frame_len() != 0) begin
                    phase     = PH_PIX;
                    pixel_num = '0;
                    byte_slot = '0;
                end else begin
                    phase = PH_HUNT;
                end
            end
            PH_PIX: begin
                if (byte_slot == 2'd0) begin
                    first_color = b;
                    byte_slot   = 2'd1;
                end else if (byte_slot == 2'd1) begin
                    second_color = b;
                    byte_slot    = 2'd2;
                end else begin
                    r  = first_color;
                    g  = second_color;
                    bl = b;
                    case (color_order)
                        CO_SWAP_GB: {g, bl} = {bl, g};
                        CO_SWAP_RG: {r, g} = {g, r};
                        CO_ROTATE:  {r, g, bl} = {g, bl, r};
                        default: ;
                    endcase
                    px.pixel_index = pixel_num;
                    px.red         = r;
                    px.green       = g;
                    px.blue        = bl;
                    px.frame_end   = (int'(pixel_num) + 1 >= frame_len());
                    pixel_expect_q.push_back(px);
                    byte_slot = '0;
                    if (px.frame_end) begin
                        phase     = PH_HUNT;
                        pixel_num = '0;
                    end else begin
                        pixel_num = pixel_num + 8'd1;
                    end
                end
            end
            default: phase = PH_HUNT;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            color_order  = CO_PASS;
            led_count    = LED_COUNT_RESET;
            phase        = PH_HUNT;
            count_hi     = '0;
            count_lo     = '0;
            pixel_num    = '0;
            byte_slot    = '0;
            first_color  = '0;
            second_color = '0;
            pixel_expect_q.delete();
        end else begin
            // pixel out first: it is always older than a byte taken this edge
            if (pix_ch.valid && pix_ch.ready) begin
                if (pixel_expect_q.size() == 0) begin
                    flag_mismatch($sformatf("pixel %0d with nothing expected",
                                            pix_ch.pixel_index));
                end else begin
                    want = pixel_expect_q.pop_front();
                    check_field("pixel_index", pix_ch.pixel_index, want.pixel_index);
                    check_field("red", pix_ch.red, want.red);
                    check_field("green", pix_ch.green, want.green);
                    check_field("blue", pix_ch.blue, want.blue);
                    check_field("frame_end", pix_ch.frame_end, want.frame_end);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_COLOR_ORDER: color_order = cfg_ch.data[2:0];
                    CFG_LED_COUNT:   led_count = cfg_ch.data;
                    default: ;
                endcase
            end
            if (byte_ch.valid && byte_ch.ready) begin
                decode_byte(byte_ch.data_byte);
            end
        end
        o_pending <= pixel_expect_q.size();
    end

endmodule

[test/led_frame_header_pixel_decoder_test.sv]
`timescale 1ns / 100ps

// Drives serial bytes and register writes into the LED frame decoder, pulls
// pixels out with random back-pressure, and leaves all prediction and
// comparison to the checker instance beside the DUT.
module led_frame_header_pixel_decoder_test;
    import lfd_pkg::*;

    // quiet cycles (nothing taken on any channel) before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // long receiver hold-off, well past the one-deep output register
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BYTES = 12;

    // idling modes: none, sender only, receiver only, both
    localparam int SEND_IDLE [4] = '{0, 52, 0, 27};
    localparam int RECV_STALL [4] = '{0, 0, 52, 27};

    // led_count per random phase; small frames keep the triples dense,
    // zero checks that a good header is dropped
    localparam int PHASE_COUNT [12] = '{1, 2, 3, 5, 4, 7, 6, 8, 2, 0, 3, 1};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lfd_byte_if byte_ch();
    lfd_pix_if  pix_ch();
    lfd_cfg_if  cfg_ch();

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic long_hold = 1'b0;
    int   pending;
    int   mismatches;
    int   quiet_cycles = 0;
    int   bytes_sent = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    led_frame_header_pixel_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_pix   (pix_ch),
        .i_cfg   (cfg_ch)
    );

    lfd_pixel_checker pixel_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .byte_ch      (byte_ch),
        .pix_ch       (pix_ch),
        .cfg_ch       (cfg_ch),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    // Receiver: random ready per cycle; on request it holds ready low for a
    // long stretch so the output register fills and the byte side stalls.
    initial begin
        pix_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                pix_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold <= 1'b0;
            end
            pix_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: any request taken on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_ch.valid && byte_ch.ready) || (pix_ch.valid && pix_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(input int mode);
        send_idle_pct  = SEND_IDLE[mode];
        recv_stall_pct = RECV_STALL[mode];
    endtask

    // Offers one byte, with random idle cycles ahead of it, and returns at
    // the edge that takes it. valid stays high for a back-to-back byte.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        bytes_sent++;
    endtask

    // Stops offering bytes and waits out every predicted pixel, then a few
    // cycles more since a byte that makes no pixel may still be in flight.
    task automatic drain();
        byte_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write; only called with the decoder drained.
    task automatic write_reg(input logic [LFD_CFG_IDX_W-1:0] idx,
                             input logic [LFD_CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // color_order with random upper data bits; only the low three count
    task automatic write_color_order(input logic [2:0] order);
        write_reg(CFG_COLOR_ORDER, {6'($urandom), order});
    endtask

    // Magic word, random counts and a check byte, good or corrupted.
    task automatic send_header(input bit good);
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] chk;
        hi  = 8'($urandom);
        lo  = 8'($urandom);
        chk = hi ^ lo ^ CHECK_XOR;
        if (!good) chk = chk ^ 8'($urandom_range(255, 1));
        send_byte(MAGIC_UPPER_A);
        send_byte(MAGIC_LOWER_D);
        send_byte(MAGIC_LOWER_A);
        send_byte(hi);
        send_byte(lo);
        send_byte(chk);
    endtask

    task automatic send_color_bytes(input int n);
        repeat (n) send_byte(8'($urandom));
    endtask

    // Short runs rich in magic bytes, to break and restart the match.
    task automatic send_noise();
        repeat ($urandom_range(6, 1)) begin
            case ($urandom_range(3))
                0: send_byte(MAGIC_UPPER_A);
                1: send_byte(MAGIC_LOWER_D);
                2: send_byte(MAGIC_LOWER_A);
                default: send_byte(8'($urandom));
            endcase
        end
    endtask

    // Magic word cut short, either by a fresh 'A' or by a random byte.
    task automatic send_broken_magic();
        send_byte(MAGIC_UPPER_A);
        if ($urandom_range(1)) send_byte(MAGIC_LOWER_D);
        send_byte($urandom_range(1) ? MAGIC_UPPER_A : 8'($urandom));
    endtask

    // One register setting, one idling mode; mostly whole frames with random
    // colors, the rest bad checks, broken magic words and noise.
    task automatic run_phase(input int mode, input logic [2:0] order, input int count);
        int target;
        int pick;
        drain();
        set_idling(mode);
        write_color_order(order);
        write_reg(CFG_LED_COUNT, LFD_CFG_DATA_W'(count));
        target = bytes_sent + PHASE_BYTES;
        while (bytes_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                send_header(1'b1);
                send_color_bytes(3 * count);
            end else if (pick < 85) begin
                send_header(1'b0);
            end else if (pick < 93) begin
                send_broken_magic();
            end else begin
                send_noise();
            end
        end
    endtask

    // Starts a long frame, pauses mid-frame (sometimes mid-triple), changes
    // led_count and color order, then finishes the frame under the new limit.
    // A new limit at or below the pixels already sent ends the frame on the
    // very next pixel.
    task automatic change_mid_frame(input int mode, input int start_count);
        int sent_pix;
        int partial;
        int new_count;
        int left_pix;
        drain();
        set_idling(mode);
        write_reg(CFG_LED_COUNT, LFD_CFG_DATA_W'(start_count));
        send_header(1'b1);
        sent_pix = $urandom_range(8, 2);
        partial  = $urandom_range(2);
        send_color_bytes(3 * sent_pix + partial);
        drain();
        new_count = $urandom_range(sent_pix + 3, 1);
        write_reg(CFG_LED_COUNT, LFD_CFG_DATA_W'(new_count));
        write_color_order(3'($urandom));
        left_pix = (new_count > sent_pix) ? new_count - sent_pix : 1;
        send_color_bytes(3 * left_pix - partial);
    endtask

    initial begin
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_COLOR_ORDER;
        cfg_ch.data       = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one-pixel frame behind a magic word restarted by 'A',
        // with extreme counts and colors.
        set_idling(0);
        write_reg(CFG_LED_COUNT, 9'd1);
        send_byte(MAGIC_UPPER_A);
        send_byte(MAGIC_UPPER_A);
        send_byte(MAGIC_LOWER_D);
        send_byte(MAGIC_LOWER_A);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00 ^ 8'hFF ^ CHECK_XOR);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        // restart after 'A','d', then a bad check byte sends it back hunting
        send_byte(MAGIC_UPPER_A);
        send_byte(MAGIC_LOWER_D);
        send_byte(MAGIC_UPPER_A);
        send_byte(MAGIC_LOWER_D);
        send_byte(MAGIC_LOWER_A);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h12 ^ 8'h34 ^ CHECK_XOR ^ 8'h01);
        send_byte(MAGIC_LOWER_D);
        send_byte(MAGIC_LOWER_A);
        // zero pixel count: a good header is dropped, bytes after it are hunted
        drain();
        write_reg(CFG_LED_COUNT, 9'd0);
        send_byte(MAGIC_UPPER_A);
        send_byte(MAGIC_LOWER_D);
        send_byte(MAGIC_LOWER_A);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(CHECK_XOR);
        send_byte(8'hFF);
        send_byte(8'hFF);

        // Random phases over every color order, unused codes included,
        // cycling through the idling modes.
        for (int ph = 0; ph < 12; ph++) begin
            run_phase(ph % 4, 3'(ph % 8), PHASE_COUNT[ph]);
        end

        // Limit changed mid-frame, starting at the cap and above it.
        change_mid_frame(2, 256);
        change_mid_frame(3, 511);
        change_mid_frame(1, 256);

        // Full-length frame with a count above the cap: 256 pixels, the last
        // at index 255. The receiver holds off first so the decoder fills up.
        drain();
        set_idling(0);
        recv_stall_pct = 27;
        write_color_order(CO_ROTATE);
        write_reg(CFG_LED_COUNT, 9'd300);
        long_hold <= 1'b1;
        send_header(1'b1);
        send_color_bytes(3 * 256);

        recv_stall_pct = 0;
        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
